### rtl/core/chse_pkg.sv
// Shared widths, field types and request/response codes of the hash set engine.
package chse_pkg;

   localparam int CMD_W   = 2;
   localparam int HASH_W  = 32;
   localparam int KEY_W   = 32;
   localparam int COUNT_W = 7;

   typedef logic [CMD_W-1:0]   cmd_type;
   typedef logic [HASH_W-1:0]  hash_type;
   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [COUNT_W-1:0] count_type;

   // Command codes; any other code only looks the key up
   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_DELETE = 2'd1;

   // Response status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

endpackage

### rtl/core/chse_req_if.sv
// Request channel: command, hash and key with a valid/ready handshake.
interface chse_req_if import chse_pkg::*; ();

   logic     valid;
   logic     ready;
   cmd_type  command;
   hash_type hash_value;
   key_type  key_value;

   modport source (output valid, command, hash_value, key_value, input ready);
   modport sink   (input valid, command, hash_value, key_value, output ready);

endinterface

### rtl/core/chse_rsp_if.sv
// Response channel: status, found flag and element count with a valid/ready handshake.
interface chse_rsp_if import chse_pkg::*; ();

   logic      valid;
   logic      ready;
   logic      status;
   logic      found;
   count_type element_count;

   modport source (output valid, status, found, element_count, input ready);
   modport sink   (input valid, status, found, element_count, output ready);

endinterface

### rtl/core/chained_hash_set_engine_unit.sv
// Chained hash set engine: bucket heads, entry chains and a free list walked by one sequencer.
// Sequence: after the request transfer, the hash reduction (S_MOD, only when BUCKETS is not a
// power of two), the bucket head read (S_HEAD), the chain walk (S_WALK) over the entries passed
// before a hit or the chain end, the command (S_ACT), the append (S_LINK, successful inserts only), S_OUT.
// Throughput: one request at a time; the next can be taken the cycle after the response transfer.
// Reset: synchronous; a clearing pass over max(BUCKETS, CAPACITY) addresses runs with ready low.
module chained_hash_set_engine_unit
   import chse_pkg::*;
#(
   parameter int CAPACITY = 64,
   parameter int BUCKETS  = 256,
   parameter int KEY_BITS = 32
) (
   input logic        clock,
   input logic        reset,
   chse_req_if.sink   req_chan,
   chse_rsp_if.source rsp_chan
);

   // Index widths: IW also holds the empty marker CAPACITY
   localparam int IW        = $clog2(CAPACITY + 1);
   localparam int EW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int BW        = $clog2(BUCKETS);
   localparam int KW        = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
   localparam int CLEAR_LEN = (BUCKETS > CAPACITY) ? BUCKETS : CAPACITY;
   localparam int CW        = $clog2(CLEAR_LEN);
   localparam int SW        = $clog2(HASH_W);
   localparam bit HASH_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

   localparam logic [IW-1:0] NIL        = IW'(CAPACITY);
   localparam logic [IW-1:0] LAST_ENTRY = IW'(CAPACITY - 1);
   localparam logic [CW:0]   BUCKETS_C  = (CW + 1)'(BUCKETS);
   localparam logic [CW:0]   CAPACITY_C = (CW + 1)'(CAPACITY);
   localparam logic [CW-1:0] CLEAR_LAST = CW'(CLEAR_LEN - 1);
   localparam logic [HASH_W-1:0] RECIP     = HASH_W'((64'd1 << HASH_W) / BUCKETS);
   localparam logic [HASH_W-1:0] BUCKETS_H = HASH_W'(BUCKETS);
   localparam logic [SW-1:0] MOD_SUB    = SW'(1);

   // Sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MOD   = 3'd2;
   localparam logic [2:0] S_HEAD  = 3'd3;
   localparam logic [2:0] S_WALK  = 3'd4;
   localparam logic [2:0] S_ACT   = 3'd5;
   localparam logic [2:0] S_LINK  = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   // Storage
   logic [IW-1:0] bucket_head_mem [BUCKETS];
   logic [KW-1:0] entry_key_mem   [CAPACITY];
   logic [IW-1:0] entry_link_mem  [CAPACITY];
   logic [IW-1:0] free_link_mem   [CAPACITY];

   // Control and request registers
   logic [2:0]        state_ff, state_in;
   logic [CW-1:0]     clr_ff, clr_in;
   cmd_type           cmd_ff, cmd_in;
   hash_type          hash_ff, hash_in;
   logic [KW-1:0]     key_ff, key_in;
   logic [BW-1:0]     bucket_ff, bucket_in;
   logic [SW-1:0]     mod_cnt_ff, mod_cnt_in;
   logic [2*HASH_W-1:0] prod_ff, prod_in;
   hash_type          rem_ff, rem_in;
   logic [IW-1:0]     cur_ff, cur_in;
   logic [IW-1:0]     pred_ff, pred_in;
   logic [IW-1:0]     steps_ff, steps_in;
   logic [IW-1:0]     next_ff, next_in;
   logic [IW-1:0]     new_ff, new_in;
   logic              found_ff, found_in;
   logic              status_ff, status_in;
   logic [IW-1:0]     count_ff, count_in;
   logic [IW-1:0]     free_head_ff, free_head_in;

   // Registered memory read data
   logic [IW-1:0]     head_rd_ff;
   logic [KW-1:0]     key_rd_ff;
   logic [IW-1:0]     link_rd_ff;
   logic [IW-1:0]     flink_rd_ff;

   // Write ports
   logic              head_we;
   logic [BW-1:0]     head_waddr;
   logic [IW-1:0]     head_wdata;
   logic              key_we;
   logic [EW-1:0]     key_waddr;
   logic              link_we;
   logic [EW-1:0]     link_waddr;
   logic [IW-1:0]     link_wdata;
   logic              flink_we;
   logic [EW-1:0]     flink_waddr;
   logic [IW-1:0]     flink_wdata;

   hash_type                quot_b;
   logic [IW+COUNT_W-1:0]   count_ext;
   logic                    is_insert;
   logic                    is_delete;

   assign is_insert = (cmd_ff == CMD_INSERT);
   assign is_delete = (cmd_ff == CMD_DELETE);
   assign quot_b    = prod_ff[2*HASH_W-1:HASH_W] * BUCKETS_H;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      hash_in      = hash_ff;
      key_in       = key_ff;
      bucket_in    = bucket_ff;
      mod_cnt_in   = mod_cnt_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      cur_in       = cur_ff;
      pred_in      = pred_ff;
      steps_in     = steps_ff;
      next_in      = next_ff;
      new_in       = new_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      free_head_in = free_head_ff;

      head_we      = 1'b0;
      head_waddr   = bucket_ff;
      head_wdata   = NIL;
      key_we       = 1'b0;
      key_waddr    = free_head_ff[EW-1:0];
      link_we      = 1'b0;
      link_waddr   = pred_ff[EW-1:0];
      link_wdata   = NIL;
      flink_we     = 1'b0;
      flink_waddr  = cur_ff[EW-1:0];
      flink_wdata  = free_head_ff;

      unique case (state_ff)
         // Sweep bucket heads to empty and thread the initial free list
         S_CLEAR: begin
            head_we     = ({1'b0, clr_ff} < BUCKETS_C);
            head_waddr  = clr_ff[BW-1:0];
            head_wdata  = NIL;
            flink_we    = ({1'b0, clr_ff} < CAPACITY_C);
            flink_waddr = clr_ff[EW-1:0];
            flink_wdata = (clr_ff == '0) ? NIL : IW'(clr_ff - 1'b1);
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == CLEAR_LAST) begin
               state_in = S_IDLE;
            end
         end
         // Take a request transfer
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in     = req_chan.command;
               hash_in    = req_chan.hash_value;
               key_in     = req_chan.key_value[KW-1:0];
               mod_cnt_in = '0;
               if (HASH_POW2) begin
                  bucket_in = req_chan.hash_value[BW-1:0];
                  state_in  = S_HEAD;
               end else begin
                  bucket_in = '0;
                  state_in  = S_MOD;
               end
            end
         end
         // Reduce the hash: reciprocal product, subtract, then one corrective subtract
         S_MOD: begin
            mod_cnt_in = mod_cnt_ff + 1'b1;
            priority if (mod_cnt_ff == '0) begin
               prod_in = {{HASH_W{1'b0}}, hash_ff} * {{HASH_W{1'b0}}, RECIP};
            end else if (mod_cnt_ff == MOD_SUB) begin
               rem_in = hash_ff - quot_b;
            end else begin
               if (rem_ff >= BUCKETS_H) begin
                  bucket_in = BW'(rem_ff - BUCKETS_H);
               end else begin
                  bucket_in = rem_ff[BW-1:0];
               end
               state_in = S_HEAD;
            end
         end
         // Start the chain walk at the bucket head
         S_HEAD: begin
            cur_in   = head_rd_ff;
            pred_in  = NIL;
            steps_in = '0;
            state_in = S_WALK;
         end
         // Compare one entry per cycle, advance along the chain
         S_WALK: begin
            priority if (cur_ff >= NIL || steps_ff == NIL) begin
               found_in = 1'b0;
               state_in = S_ACT;
            end else if (key_rd_ff == key_ff) begin
               found_in = 1'b1;
               next_in  = link_rd_ff;
               state_in = S_ACT;
            end else begin
               pred_in  = cur_ff;
               cur_in   = link_rd_ff;
               steps_in = steps_ff + 1'b1;
            end
         end
         // Apply the command
         S_ACT: begin
            status_in = STATUS_OK;
            state_in  = S_OUT;
            if (is_insert && !found_ff) begin
               if (free_head_ff >= NIL) begin
                  status_in = STATUS_FULL;
               end else begin
                  // pop a free entry and fill it
                  new_in       = free_head_ff;
                  free_head_in = flink_rd_ff;
                  key_we       = 1'b1;
                  key_waddr    = free_head_ff[EW-1:0];
                  link_we      = 1'b1;
                  link_waddr   = free_head_ff[EW-1:0];
                  link_wdata   = NIL;
                  count_in     = count_ff + 1'b1;
                  state_in     = S_LINK;
               end
            end else if (is_delete && found_ff) begin
               // join predecessor to successor, push entry on the free list
               if (pred_ff >= NIL) begin
                  head_we    = 1'b1;
                  head_wdata = next_ff;
               end else begin
                  link_we    = 1'b1;
                  link_waddr = pred_ff[EW-1:0];
                  link_wdata = next_ff;
               end
               flink_we     = 1'b1;
               flink_waddr  = cur_ff[EW-1:0];
               flink_wdata  = free_head_ff;
               free_head_in = cur_ff;
               count_in     = count_ff - 1'b1;
            end
         end
         // Append the new entry at the chain end
         S_LINK: begin
            if (pred_ff >= NIL) begin
               head_we    = 1'b1;
               head_wdata = new_ff;
            end else begin
               link_we    = 1'b1;
               link_waddr = pred_ff[EW-1:0];
               link_wdata = new_ff;
            end
            state_in = S_OUT;
         end
         // Hold the response until its transfer
         S_OUT: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         free_head_ff <= LAST_ENTRY;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_head_ff <= free_head_in;
         count_ff     <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      hash_ff    <= hash_in;
      key_ff     <= key_in;
      bucket_ff  <= bucket_in;
      mod_cnt_ff <= mod_cnt_in;
      prod_ff    <= prod_in;
      rem_ff     <= rem_in;
      cur_ff     <= cur_in;
      pred_ff    <= pred_in;
      steps_ff   <= steps_in;
      next_ff    <= next_in;
      new_ff     <= new_in;
      found_ff   <= found_in;
      status_ff  <= status_in;
   end

   // Bucket head memory: read at the next bucket
   always_ff @(posedge clock) begin
      if (head_we) begin
         bucket_head_mem[head_waddr] <= head_wdata;
      end
      head_rd_ff <= bucket_head_mem[bucket_in];
   end

   // Entry key and chain link memories: read at the next chain position
   always_ff @(posedge clock) begin
      if (key_we) begin
         entry_key_mem[key_waddr] <= key_ff;
      end
      key_rd_ff <= entry_key_mem[cur_in[EW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         entry_link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= entry_link_mem[cur_in[EW-1:0]];
   end

   // Free list memory: read at the current free head
   always_ff @(posedge clock) begin
      if (flink_we) begin
         free_link_mem[flink_waddr] <= flink_wdata;
      end
      flink_rd_ff <= free_link_mem[free_head_ff[EW-1:0]];
   end

   // Ports
   assign count_ext              = {{COUNT_W{1'b0}}, count_ff};
   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = (state_ff == S_OUT);
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.found         = found_ff;
   assign rsp_chan.element_count = count_ext[COUNT_W-1:0];

endmodule
